// ----- design/camresp_pkg.sv -----
// Shared constants, result descriptor type and CRC-8 helper for the camera command responder.
package camresp_pkg;

	localparam logic [7:0] HDR_BYTE  = 8'hCC;
	localparam logic [7:0] CRC_POLY  = 8'hD5;

	localparam logic [7:0] INFO1_RST = 8'hD7;
	localparam logic [7:0] INFO2_RST = 8'h0A;

	// configuration register indexes
	localparam logic CFG_INFO1 = 1'b0;
	localparam logic CFG_INFO2 = 1'b1;

	// commands
	localparam logic [7:0] CMD_INFO = 8'h00;
	localparam logic [7:0] CMD_CTRL = 8'h01;

	// control arguments
	localparam logic [7:0] ARG_WIFI    = 8'h00;
	localparam logic [7:0] ARG_POWER   = 8'h01;
	localparam logic [7:0] ARG_MODE    = 8'h02;
	localparam logic [7:0] ARG_REC_ON  = 8'h03;
	localparam logic [7:0] ARG_REC_OFF = 8'h04;

	// event codes
	localparam logic [3:0] EV_INFO    = 4'd0;
	localparam logic [3:0] EV_CRC_ERR = 4'd1;
	localparam logic [3:0] EV_UNKNOWN = 4'd2;
	localparam logic [3:0] EV_WIFI    = 4'd3;
	localparam logic [3:0] EV_POWER   = 4'd4;
	localparam logic [3:0] EV_MODE    = 4'd5;
	localparam logic [3:0] EV_REC_ON  = 4'd6;
	localparam logic [3:0] EV_REC_OFF = 4'd7;
	localparam logic [3:0] EV_IGNORED = 4'd8;

	// reply beats of an info answer
	localparam logic [1:0] BEAT_HDR   = 2'd0;
	localparam logic [1:0] BEAT_INFO1 = 2'd1;
	localparam logic [1:0] BEAT_INFO2 = 2'd2;
	localparam logic [1:0] BEAT_CRC   = 2'd3;

	// what a completed packet leaves for the transmit side
	typedef struct packed {
		logic       has;
		logic       info;
		logic [3:0] ev;
		logic       pwr;
		logic       hq;
		logic [7:0] crc;
		logic [7:0] info1;
		logic [7:0] info2;
	} rsp_t;

	// CRC-8, MSB first, no reflection, no final xor
	function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// ----- design/camresp_parser.sv -----
// Packet gatherer, CRC check and camera state for the command responder.
module camresp_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           info1,
	input  logic [7:0]           info2,
	output camresp_pkg::rsp_t    rsp
);

	logic       in_packet_q, in_packet_n;
	logic [1:0] count_q, count_n;
	logic [7:0] cmd_q, cmd_n;
	logic [7:0] arg_q, arg_n;
	logic [7:0] crc_q, crc_n;
	logic       pwr_q, pwr_n;
	logic       hq_q, hq_n;
	logic [7:0] crc_upd;

	assign crc_upd = camresp_pkg::crc8(in_packet_q ? crc_q : 8'h00, rx_byte);

	always_comb begin
		in_packet_n = in_packet_q;
		count_n     = count_q;
		cmd_n       = cmd_q;
		arg_n       = arg_q;
		crc_n       = crc_q;
		pwr_n       = pwr_q;
		hq_n        = hq_q;
		rsp.has     = 1'b0;
		rsp.info    = 1'b0;
		rsp.ev      = camresp_pkg::EV_UNKNOWN;
		rsp.crc     = crc_q;
		rsp.info1   = info1;
		rsp.info2   = info2;

		if (!in_packet_q) begin
			if (rx_byte == camresp_pkg::HDR_BYTE) begin
				in_packet_n = 1'b1;
				count_n     = 2'd1;
				crc_n       = crc_upd;
			end
		end else begin
			case (count_q)
				2'd1: begin
					cmd_n   = rx_byte;
					crc_n   = crc_upd;
					count_n = 2'd2;
				end
				2'd2: begin
					if (cmd_q == camresp_pkg::CMD_INFO) begin
						in_packet_n = 1'b0;
						count_n     = 2'd0;
						rsp.has     = 1'b1;
						if (rx_byte != crc_q) begin
							rsp.ev = camresp_pkg::EV_CRC_ERR;
						end else begin
							rsp.info = 1'b1;
							rsp.ev   = camresp_pkg::EV_INFO;
						end
					end else begin
						arg_n   = rx_byte;
						crc_n   = crc_upd;
						count_n = 2'd3;
					end
				end
				default: begin
					// closing CRC byte of a four-byte packet
					in_packet_n = 1'b0;
					count_n     = 2'd0;
					rsp.has     = 1'b1;
					if (rx_byte != crc_q) begin
						rsp.ev = camresp_pkg::EV_CRC_ERR;
					end else if (cmd_q != camresp_pkg::CMD_CTRL) begin
						rsp.ev = camresp_pkg::EV_UNKNOWN;
					end else if (arg_q == camresp_pkg::ARG_POWER) begin
						pwr_n  = 1'b1;
						rsp.ev = camresp_pkg::EV_POWER;
					end else if (!pwr_q) begin
						rsp.ev = camresp_pkg::EV_IGNORED;
					end else begin
						case (arg_q)
							camresp_pkg::ARG_WIFI:    rsp.ev = camresp_pkg::EV_WIFI;
							camresp_pkg::ARG_MODE: begin
								hq_n   = !hq_q;
								rsp.ev = camresp_pkg::EV_MODE;
							end
							camresp_pkg::ARG_REC_ON:  rsp.ev = camresp_pkg::EV_REC_ON;
							camresp_pkg::ARG_REC_OFF: rsp.ev = camresp_pkg::EV_REC_OFF;
							default:                  rsp.ev = camresp_pkg::EV_IGNORED;
						endcase
					end
				end
			endcase
		end
		rsp.pwr = pwr_n;
		rsp.hq  = hq_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			count_q     <= 2'd0;
			crc_q       <= 8'h00;
			pwr_q       <= 1'b0;
			hq_q        <= 1'b0;
		end else if (accept) begin
			in_packet_q <= in_packet_n;
			count_q     <= count_n;
			crc_q       <= crc_n;
			pwr_q       <= pwr_n;
			hq_q        <= hq_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_n;
			arg_q <= arg_n;
		end
	end

endmodule

// ----- design/camera_uart_command_responder.sv -----
// Top level of the camera command responder: config registers, reply register and serialiser.
//
// channel  direction  handshake            payload
// in       to block   in_valid/in_stall    rx_byte
// out      from block out_valid/out_stall  tx_valid tx_byte event_res powered high_quality last
// cfg      to block   cfg_valid/cfg_ready  cfg_index cfg_data
//
// A received byte is decoded in the cycle it is accepted; a completed packet loads the
// reply register, which sends one result per cycle while out_stall is low: four for an
// info answer, else one. The input stalls only while the reply register holds results
// that are not leaving on this edge, so with no reply held it takes one byte per cycle.
// Reset clears the packet gatherer, camera state and reply register; info bytes
// return to 0xD7 and 0x0A. cfg_ready is always high.
module camera_uart_command_responder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic [3:0] event_res,
	output logic       powered,
	output logic       high_quality,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0]         info1_q, info2_q;
	logic               accept;
	camresp_pkg::rsp_t  rsp;
	camresp_pkg::rsp_t  rsp_q;
	logic               rsp_valid_q;
	logic [1:0]         beat_q;
	logic               last_beat;
	logic               xfer;
	logic               pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info1_q <= camresp_pkg::INFO1_RST;
			info2_q <= camresp_pkg::INFO2_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				camresp_pkg::CFG_INFO1: info1_q <= cfg_data;
				camresp_pkg::CFG_INFO2: info2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign last_beat = !rsp_q.info || (beat_q == camresp_pkg::BEAT_CRC);
	assign xfer      = rsp_valid_q && !out_stall;
	assign pop       = xfer && last_beat;
	assign in_stall  = rsp_valid_q && !pop;
	assign accept    = in_valid && !in_stall;

	camresp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.info1   (info1_q),
		.info2   (info2_q),
		.rsp     (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			beat_q      <= camresp_pkg::BEAT_HDR;
		end else if (accept && rsp.has) begin
			rsp_valid_q <= 1'b1;
			beat_q      <= camresp_pkg::BEAT_HDR;
		end else if (pop) begin
			rsp_valid_q <= 1'b0;
		end else if (xfer) begin
			beat_q <= beat_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && rsp.has) begin
			rsp_q <= rsp;
		end
	end

	assign out_valid    = rsp_valid_q;
	assign tx_valid     = rsp_q.info;
	assign event_res    = rsp_q.ev;
	assign powered      = rsp_q.pwr;
	assign high_quality = rsp_q.hq;
	assign last         = last_beat;

	always_comb begin
		if (!rsp_q.info) begin
			tx_byte = 8'h00;
		end else begin
			case (beat_q)
				camresp_pkg::BEAT_HDR:   tx_byte = camresp_pkg::HDR_BYTE;
				camresp_pkg::BEAT_INFO1: tx_byte = rsp_q.info1;
				camresp_pkg::BEAT_INFO2: tx_byte = rsp_q.info2;
				default:                 tx_byte = rsp_q.crc;
			endcase
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the camera command responder: packet stimulus, reply prediction and checking.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 1000;	// far above any gap that random stalls produce
	localparam int SETTLE_CYCLES  = 8;
	localparam int CHUNK_BYTES    = 51;
	localparam int N_CHUNKS       = 6;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [3:0] ev;
		logic       pwr;
		logic       hq;
		logic       last;
	} reply_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic [3:0] event_res;
	logic       powered;
	logic       high_quality;
	logic       last;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = 1'b0;
	logic [7:0] cfg_data  = 8'h00;

	camera_uart_command_responder i_dut (.*);

	// stimulus and expectations
	logic [7:0] rx_pending[$];
	reply_t     reply_q[$];
	logic       in_taken = 1'b0;
	int         send_idle = 0;
	int         recv_idle = 0;
	int         quiet_cycles = 0;
	int         err_count = 0;
	int         n_rx = 0;
	int         n_replies = 0;
	int         n_packets = 0;
	int         n_info = 0;

	// predicted camera state
	logic       pkt_open = 1'b0;
	logic [2:0] pkt_cnt  = 3'd0;
	logic [7:0] pkt_cmd  = 8'h00;
	logic [7:0] pkt_arg  = 8'h00;
	logic [7:0] pkt_crc  = 8'h00;
	logic       cam_on   = 1'b0;
	logic       cam_hq   = 1'b0;
	logic [7:0] info1_reg = camresp_pkg::INFO1_RST;
	logic [7:0] info2_reg = camresp_pkg::INFO2_RST;

	initial begin
		forever #5 clk = ~clk;
	end

	// CRC-8, polynomial 0xD5, MSB first
	function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] d);
		logic [7:0] r;
		r = c ^ d;
		repeat (8) r = r[7] ? ((r << 1) ^ camresp_pkg::CRC_POLY) : (r << 1);
		return r;
	endfunction

	task automatic push_reply(input logic v, input logic [7:0] b, input logic [3:0] ev,
			input logic lst);
		reply_t r;
		r.tx_valid = v;
		r.tx_byte  = b;
		r.ev       = ev;
		r.pwr      = cam_on;
		r.hq       = cam_hq;
		r.last     = lst;
		reply_q.push_back(r);
	endtask

	task automatic decode_rx_byte(input logic [7:0] b);
		logic [3:0] ev;
		if (!pkt_open) begin
			if (b == camresp_pkg::HDR_BYTE) begin
				pkt_open = 1'b1;
				pkt_cnt  = 3'd1;
				pkt_crc  = crc_step(8'h00, b);
			end
		end else if (pkt_cnt == 3'd1) begin
			pkt_cmd = b;
			pkt_crc = crc_step(pkt_crc, b);
			pkt_cnt = 3'd2;
		end else if (pkt_cnt == 3'd2 && pkt_cmd == camresp_pkg::CMD_INFO) begin
			pkt_open = 1'b0;
			pkt_cnt  = 3'd0;
			n_packets++;
			if (b != pkt_crc) begin
				push_reply(1'b0, 8'h00, camresp_pkg::EV_CRC_ERR, 1'b1);
			end else begin
				n_info++;
				push_reply(1'b1, camresp_pkg::HDR_BYTE, camresp_pkg::EV_INFO, 1'b0);
				push_reply(1'b1, info1_reg, camresp_pkg::EV_INFO, 1'b0);
				push_reply(1'b1, info2_reg, camresp_pkg::EV_INFO, 1'b0);
				push_reply(1'b1, pkt_crc, camresp_pkg::EV_INFO, 1'b1);
			end
		end else if (pkt_cnt == 3'd2) begin
			pkt_arg = b;
			pkt_crc = crc_step(pkt_crc, b);
			pkt_cnt = 3'd3;
		end else begin
			pkt_open = 1'b0;
			pkt_cnt  = 3'd0;
			n_packets++;
			if (b != pkt_crc) begin
				ev = camresp_pkg::EV_CRC_ERR;
			end else if (pkt_cmd != camresp_pkg::CMD_CTRL) begin
				ev = camresp_pkg::EV_UNKNOWN;
			end else if (pkt_arg == camresp_pkg::ARG_POWER) begin
				cam_on = 1'b1;
				ev = camresp_pkg::EV_POWER;
			end else if (!cam_on) begin
				ev = camresp_pkg::EV_IGNORED;
			end else begin
				case (pkt_arg)
					camresp_pkg::ARG_WIFI:    ev = camresp_pkg::EV_WIFI;
					camresp_pkg::ARG_MODE: begin
						cam_hq = ~cam_hq;
						ev = camresp_pkg::EV_MODE;
					end
					camresp_pkg::ARG_REC_ON:  ev = camresp_pkg::EV_REC_ON;
					camresp_pkg::ARG_REC_OFF: ev = camresp_pkg::EV_REC_OFF;
					default:                  ev = camresp_pkg::EV_IGNORED;
				endcase
			end
			push_reply(1'b0, 8'h00, ev, 1'b1);
		end
	endtask

	task automatic check_reply();
		reply_t exp_r;
		if (reply_q.size() == 0) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t: unexpected reply transaction byte=%02h ev=%0d", $realtime,
					tx_byte, event_res);
		end else begin
			exp_r = reply_q.pop_front();
			if (exp_r.tx_valid !== tx_valid || exp_r.tx_byte !== tx_byte ||
					exp_r.ev !== event_res || exp_r.pwr !== powered ||
					exp_r.hq !== high_quality || exp_r.last !== last) begin
				err_count++;
				if (err_count <= MAX_REPORTS) begin
					$display("%0t: reply mismatch, expected v=%0b byte=%02h ev=%0d pwr=%0b hq=%0b last=%0b",
						$realtime, exp_r.tx_valid, exp_r.tx_byte, exp_r.ev, exp_r.pwr,
						exp_r.hq, exp_r.last);
					$display("%0t:                 actual v=%0b byte=%02h ev=%0d pwr=%0b hq=%0b last=%0b",
						$realtime, tx_valid, tx_byte, event_res, powered, high_quality,
						last);
				end
			end
		end
	endtask

	task automatic queue_packet(input logic [7:0] cmd, input logic [7:0] arg,
			input logic corrupt);
		logic [7:0] c;
		c = crc_step(crc_step(8'h00, camresp_pkg::HDR_BYTE), cmd);
		rx_pending.push_back(camresp_pkg::HDR_BYTE);
		rx_pending.push_back(cmd);
		if (cmd != camresp_pkg::CMD_INFO) begin
			rx_pending.push_back(arg);
			c = crc_step(c, arg);
		end
		if (corrupt)
			c ^= 8'h01 << $urandom_range(7);
		rx_pending.push_back(c);
	endtask

	// one random unit of traffic; noise bytes are not counted
	task automatic queue_random_unit(output int counted);
		int pick;
		int k;
		logic [7:0] c;
		pick = $urandom_range(99);
		counted = 0;
		if (pick < 10) begin
			k = $urandom_range(1, 3);
			repeat (k) rx_pending.push_back(8'($urandom));
		end else if (pick < 16) begin
			// cut short: whatever follows is taken as the rest of this packet
			k = $urandom_range(1, 2);
			rx_pending.push_back(camresp_pkg::HDR_BYTE);
			repeat (k) rx_pending.push_back(8'($urandom));
			counted = k + 1;
		end else if (pick < 40) begin
			queue_packet(camresp_pkg::CMD_INFO, 8'h00, $urandom_range(99) < 12);
			counted = 3;
		end else if (pick < 88) begin
			c = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4));
			queue_packet(camresp_pkg::CMD_CTRL, c, $urandom_range(99) < 12);
			counted = 4;
		end else begin
			do c = 8'($urandom);
			while (c == camresp_pkg::CMD_INFO || c == camresp_pkg::CMD_CTRL);
			queue_packet(c, 8'($urandom), $urandom_range(99) < 12);
			counted = 4;
		end
	endtask

	task automatic write_info(input logic [7:0] b1, input logic [7:0] b2);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= camresp_pkg::CFG_INFO1;
		cfg_data  <= b1;
		do @(posedge clk); while (!cfg_ready);
		info1_reg = b1;
		@(negedge clk);
		cfg_index <= camresp_pkg::CFG_INFO2;
		cfg_data  <= b2;
		do @(posedge clk); while (!cfg_ready);
		info2_reg = b2;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (rx_pending.size() != 0 || in_valid || reply_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// byte driver: holds a stalled transaction, otherwise idles at random
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
				in_valid <= 1'b1;
				rx_byte  <= rx_pending.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// monitor and predictor
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_replies++;
				check_reply();
			end
			if (in_valid && !in_stall) begin
				n_rx++;
				decode_rx_byte(rx_byte);
			end
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int chunk;
		int added;
		int n;
		send_idle = 38;
		recv_idle = 46;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset info bytes, camera starts off
		rx_pending.push_back(8'hFF);
		queue_packet(camresp_pkg::CMD_CTRL, camresp_pkg::ARG_WIFI, 1'b0);
		queue_packet(camresp_pkg::CMD_CTRL, camresp_pkg::ARG_POWER, 1'b0);
		queue_packet(camresp_pkg::CMD_INFO, 8'h00, 1'b0);
		queue_packet(camresp_pkg::CMD_CTRL, camresp_pkg::ARG_MODE, 1'b0);
		queue_packet(camresp_pkg::CMD_CTRL, camresp_pkg::ARG_REC_ON, 1'b0);
		queue_packet(camresp_pkg::CMD_CTRL, camresp_pkg::ARG_REC_OFF, 1'b0);
		queue_packet(camresp_pkg::CMD_INFO, 8'h00, 1'b1);
		queue_packet(camresp_pkg::HDR_BYTE, camresp_pkg::HDR_BYTE, 1'b0);
		settle();

		for (chunk = 0; chunk < N_CHUNKS; chunk++) begin
			if (chunk < 2) begin
				send_idle = 38;
				recv_idle = 46;
			end else if (chunk < 4) begin
				send_idle = 46;
				recv_idle = 38;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			case (chunk)
				0: write_info(8'hFF, 8'h00);
				1: write_info(8'h00, 8'hFF);
				3: write_info(8'hFF, 8'hFF);
				4: write_info(8'h00, 8'h00);
				default: write_info(8'($urandom), 8'($urandom));
			endcase
			added = 0;
			while (added < CHUNK_BYTES) begin
				queue_random_unit(n);
				added += n;
			end
			settle();
		end

		$display("summary: %0d bytes received, %0d packets closed, %0d reply transactions checked",
			n_rx, n_packets, n_replies);
		$display("summary: %0d info replies over %0d info settings, %0d failures",
			n_info, N_CHUNKS + 1, err_count);
		if (err_count == 0 && reply_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
design/camresp_pkg.sv
design/camresp_parser.sv
design/camera_uart_command_responder.sv
bench/tb_top.sv
